>>> hdl/ekd_pkg.sv
// Shared types and constants for the encoder detent key event block.
// Used by ekd_ctrl, ekd_datapath and encoder_detent_key_events; no dependencies.
package ekd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DELTA_W         = 16;
  localparam int DETENT_W        = 8;
  localparam int REM_W           = 9;
  localparam int DIV_CNT_W       = 4;
  localparam int CFG_INDEX_W     = 2;
  localparam int S_TDATA_W       = 24;
  localparam int M_TDATA_W       = 8;

  localparam logic [DETENT_W-1:0]    DETENT_RESET = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DETENT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON   = 2'd1;

  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_DOWN  = 2'd1,
    KEY_UP    = 2'd2,
    KEY_ENTER = 2'd3
  } key_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_finish;
    logic push;
    logic push_enter;
    logic push_pressed;
    logic dec_detent;
    logic button_update;
    logic set_drop;
    logic read_head;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic detents_zero;
    logic full;
    logic button_change;
    logic out_free;
  } status_t;

endpackage

>>> hdl/ekd_datapath.sv
// Datapath of the encoder detent key event block: configuration registers,
// serial divider, event queue memory and result register. Depends on ekd_pkg.
module ekd_datapath #(
  parameter int QUEUE_DEPTH = ekd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ekd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ekd_pkg::DETENT_W-1:0]      cfg_data,
  input  logic [ekd_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ekd_pkg::M_TDATA_W-1:0]     m_tdata,
  input  ekd_pkg::cmd_t                     cmd,
  output ekd_pkg::status_t                  status
);
  import ekd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DETENT_W-1:0]  detent_pulses;
  logic                 button_enable;
  logic signed [REM_W-1:0] rem_acc;
  logic                 button_state;
  logic                 level;
  logic                 read_ok;
  logic                 neg;
  logic [DELTA_W-1:0]   dq;
  logic [DETENT_W-1:0]  part;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DELTA_W-1:0]   detents;
  logic                 dropped;
  logic [2:0]           queue_mem [QUEUE_DEPTH];
  logic [2:0]           rd_data;
  logic [PTR_W-1:0]     head;
  logic [PTR_W-1:0]     tail;
  logic [CNT_W-1:0]     count;
  key_t                 out_key;
  logic                 out_pressed;
  logic                 out_more;
  logic                 out_dropped;

  logic [DETENT_W-1:0]      divisor;
  logic signed [DELTA_W:0]  total;
  logic [DELTA_W:0]         total_mag;
  logic [DETENT_W:0]        trial;
  logic [DETENT_W:0]        diff;
  logic                     qbit;
  logic [REM_W-1:0]         rem_mag;
  logic [2:0]               push_entry;
  logic                     full;
  key_t                     dir_key;

  assign divisor   = (detent_pulses == '0) ? DETENT_W'(1) : detent_pulses;
  assign total     = (DELTA_W+1)'(rem_acc)
                   + (DELTA_W+1)'($signed(s_tdata[DELTA_W-1:0]));
  assign total_mag = total[DELTA_W] ? (DELTA_W+1)'(-total) : (DELTA_W+1)'(total);
  assign trial     = {part, dq[DELTA_W-1]};
  assign diff      = trial - {1'b0, divisor};
  assign qbit      = (trial >= {1'b0, divisor});
  assign rem_mag   = {1'b0, part};
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign dir_key   = neg ? KEY_UP : KEY_DOWN;
  assign push_entry = cmd.push_enter ? {KEY_ENTER, level} : {dir_key, cmd.push_pressed};

  assign status.div_last      = (div_cnt == '0);
  assign status.detents_zero  = (detents == '0);
  assign status.full          = full;
  assign status.button_change = button_enable && read_ok && (level != button_state);
  assign status.out_free      = !m_tvalid || m_tready;

  assign m_tdata = {3'b000, out_dropped, out_more, out_pressed, out_key};

  always_ff @(posedge clk) begin
    if (rst) begin
      detent_pulses   <= DETENT_RESET;
      button_enable   <= 1'b1;
      rem_acc         <= '0;
      button_state    <= 1'b0;
      head            <= '0;
      tail            <= '0;
      count           <= '0;
      m_tvalid        <= 1'b0;
      dropped         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DETENT: detent_pulses <= cfg_data;
          REG_BUTTON: button_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        dropped <= 1'b0;
      end
      if (cmd.set_drop) begin
        dropped <= 1'b1;
      end
      if (cmd.div_finish) begin
        rem_acc <= neg ? $signed(REM_W'(0) - rem_mag) : $signed(rem_mag);
      end
      if (cmd.button_update) begin
        button_state <= level;
      end
      if (cmd.push) begin
        tail  <= (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.emit && count != '0) begin
        head  <= (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      level   <= s_tdata[DELTA_W];
      read_ok <= s_tdata[DELTA_W+1];
      neg     <= total[DELTA_W];
      dq      <= total_mag[DELTA_W-1:0];
      part    <= '0;
      div_cnt <= DIV_CNT_W'(DELTA_W - 1);
    end
    if (cmd.div_step) begin
      dq      <= {dq[DELTA_W-2:0], qbit};
      part    <= qbit ? diff[DETENT_W-1:0] : trial[DETENT_W-1:0];
      div_cnt <= div_cnt - 1'b1;
    end
    if (cmd.div_finish) begin
      detents <= dq;
    end
    if (cmd.dec_detent) begin
      detents <= detents - 1'b1;
    end
    if (cmd.push) begin
      queue_mem[tail] <= push_entry;
    end
    if (cmd.read_head) begin
      rd_data <= queue_mem[head];
    end
    if (cmd.emit) begin
      out_dropped <= dropped;
      if (count != '0) begin
        out_key     <= key_t'(rd_data[2:1]);
        out_pressed <= rd_data[0];
        out_more    <= (count > CNT_W'(1));
      end else begin
        out_key     <= KEY_NONE;
        out_pressed <= 1'b0;
        out_more    <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds depth.");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && full))
    else $error("Push issued while the queue is full.");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("Emit did not raise the output valid.");

  a_empty_none: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && count == '0) |=> (m_tdata[1:0] == KEY_NONE && !m_tdata[3]))
    else $error("Empty queue reported an event.");

endmodule

>>> hdl/ekd_ctrl.sv
// Controller state machine of the encoder detent key event block.
// Sequences divide, pushes, button check and pop; depends on ekd_pkg.
module ekd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ekd_pkg::status_t  status,
  output ekd_pkg::cmd_t     cmd
);
  import ekd_pkg::*;

  typedef enum logic [2:0] {
    IDLE, DIV, FINISH, PUSH_PRESS, PUSH_RELEASE, BUTTON, READ, EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = DIV;
        end
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        cmd.div_finish = 1'b1;
        state_next     = PUSH_PRESS;
      end
      PUSH_PRESS: begin
        if (status.detents_zero) begin
          state_next = BUTTON;
        end else if (status.full) begin
          cmd.set_drop = 1'b1;
          state_next   = BUTTON;
        end else begin
          cmd.push         = 1'b1;
          cmd.push_pressed = 1'b1;
          state_next       = PUSH_RELEASE;
        end
      end
      PUSH_RELEASE: begin
        if (status.full) begin
          cmd.set_drop = 1'b1;
          state_next   = BUTTON;
        end else begin
          cmd.push       = 1'b1;
          cmd.dec_detent = 1'b1;
          state_next     = PUSH_PRESS;
        end
      end
      BUTTON: begin
        if (status.button_change) begin
          cmd.button_update = 1'b1;
          if (status.full) begin
            cmd.set_drop = 1'b1;
          end else begin
            cmd.push       = 1'b1;
            cmd.push_enter = 1'b1;
          end
        end
        state_next = READ;
      end
      READ: begin
        cmd.read_head = 1'b1;
        state_next    = EMIT;
      end
      EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/encoder_detent_key_events.sv
// Top level of the encoder detent key event block: one poll in, one key event out.
// Each poll runs the serial divider, then writes a press and a release event per detent
// (at most QUEUE_DEPTH/2 press events per poll), checks the button and reads the queue head.
// No new poll is taken until a result is emitted; a result held by m_tready stalls s_tready.
// Reset (synchronous, rst high) empties the queue, zeros the remainder,
// releases the button state and loads detent_pulses 4 and button_enable 1.
module encoder_detent_key_events #(
  parameter int QUEUE_DEPTH = ekd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ekd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ekd_pkg::DETENT_W-1:0]      cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: pulse_delta[15:0], button_level, button_read_ok.
  input  logic [ekd_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: key_code[1:0], key_pressed, more_pending, events_dropped.
  output logic [ekd_pkg::M_TDATA_W-1:0]     m_tdata
);
  import ekd_pkg::*;

  cmd_t    cmd;
  status_t status;

  ekd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ekd_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> sim/encoder_detent_key_events_checker.sv
// Checker for encoder_detent_key_events: watches the register port and both streams,
// predicts each key event from its own copy of the wheel and queue state, and compares.
// Depends on ekd_pkg for widths, register indexes and key codes.
module encoder_detent_key_events_checker #(
  parameter int QUEUE_DEPTH = ekd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ekd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ekd_pkg::DETENT_W-1:0]    cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [ekd_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [ekd_pkg::M_TDATA_W-1:0]   m_tdata,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ekd_pkg::*;

  typedef struct {
    key_t key;
    logic pressed;
    logic more;
    logic dropped;
  } key_event_t;

  key_event_t          expected_events[$];
  logic [DETENT_W-1:0] detent_pulses_cfg;
  logic                button_en_cfg;
  int                  wheel_remainder;
  logic                button_held;
  logic [2:0]          key_fifo[QUEUE_DEPTH];
  int                  fifo_head;
  int                  fifo_count;
  logic                poll_dropped;
  int                  mismatches;

  task automatic push_key(input key_t key, input logic pressed);
    if (fifo_count >= QUEUE_DEPTH) begin
      poll_dropped = 1'b1;
    end else begin
      key_fifo[(fifo_head + fifo_count) % QUEUE_DEPTH] = {key, pressed};
      fifo_count++;
    end
  endtask

  task automatic predict_poll(input logic [S_TDATA_W-1:0] poll);
    int         delta;
    int         divisor;
    int         total;
    int         detents;
    int         steps;
    key_t       wheel_key;
    logic       level;
    logic       read_ok;
    logic [2:0] entry;
    key_event_t ev;
    delta   = int'($signed(poll[15:0]));
    level   = poll[16];
    read_ok = poll[17];
    divisor = (detent_pulses_cfg == '0) ? 1 : int'(detent_pulses_cfg);
    poll_dropped = 1'b0;

    // Integer division in SystemVerilog truncates toward zero, as the block does.
    total           = wheel_remainder + delta;
    detents         = total / divisor;
    wheel_remainder = total % divisor;
    wheel_key       = (detents >= 0) ? KEY_DOWN : KEY_UP;
    steps           = (detents >= 0) ? detents : -detents;
    for (int i = 0; i < steps; i++) begin
      if (fifo_count >= QUEUE_DEPTH) begin
        poll_dropped = 1'b1;
        break;
      end
      push_key(wheel_key, 1'b1);
      push_key(wheel_key, 1'b0);
    end

    if (button_en_cfg && read_ok && level != button_held) begin
      button_held = level;
      push_key(KEY_ENTER, level);
    end

    if (fifo_count > 0) begin
      entry      = key_fifo[fifo_head];
      fifo_head  = (fifo_head + 1) % QUEUE_DEPTH;
      fifo_count--;
      ev.key     = key_t'(entry[2:1]);
      ev.pressed = entry[0];
      ev.more    = (fifo_count > 0);
    end else begin
      ev.key     = KEY_NONE;
      ev.pressed = 1'b0;
      ev.more    = 1'b0;
    end
    ev.dropped = poll_dropped;
    expected_events.push_back(ev);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    key_event_t ev;
    if (rst) begin
      detent_pulses_cfg = DETENT_RESET;
      button_en_cfg     = 1'b1;
      wheel_remainder   = 0;
      button_held       = 1'b0;
      fifo_head         = 0;
      fifo_count        = 0;
      mismatches        = 0;
      expected_events.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: key event transfer expected none, actual tdata %0h", $time, m_tdata);
          mismatches++;
        end else begin
          ev = expected_events.pop_front();
          compare_field("key_code", int'(ev.key), int'(m_tdata[1:0]));
          compare_field("key_pressed", int'(ev.pressed), int'(m_tdata[2]));
          compare_field("more_pending", int'(ev.more), int'(m_tdata[3]));
          compare_field("events_dropped", int'(ev.dropped), int'(m_tdata[4]));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DETENT: detent_pulses_cfg = cfg_data;
          REG_BUTTON: button_en_cfg = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predict_poll(s_tdata);
      end
    end
    fail_count <= mismatches;
    pending    <= expected_events.size();
  end

endmodule

>>> sim/encoder_detent_key_events_tb.sv
// Testbench top for encoder_detent_key_events: clock, reset, register writes and poll
// stimulus with random idling on both streams; the checker instance judges the results.
// Depends on ekd_pkg, the block and encoder_detent_key_events_checker.
module encoder_detent_key_events_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ekd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int PLAN_RANDOM  = -1;
  localparam int PLAN_SIZE    = 12;
  localparam int POLLS_PER_SETTING = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DETENT_W-1:0]    cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  // Fields from bit 0: pulse_delta[15:0], button_level, button_read_ok.
  logic [S_TDATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  // Fields from bit 0: key_code[1:0], key_pressed, more_pending, events_dropped.
  logic [M_TDATA_W-1:0]   m_tdata;
  int                     fail_count;
  int                     pending;

  int   tx_gap_pct = 0;
  int   rx_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   cur_divisor = 4;
  logic btn_level = 1'b0;

  int   detent_plan[PLAN_SIZE] = '{4, 1, 255, 0, 2, 3, PLAN_RANDOM, 255, 1, PLAN_RANDOM, 0, 4};
  logic enable_plan[PLAN_SIZE] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
                                   1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  encoder_detent_key_events dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  encoder_detent_key_events_checker key_event_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("encoder_detent_key_events_tb failed");
    $finish;
  end

  // Receiver side: random stalls, or one long hold-off while the poll side keeps offering.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_poll(input logic [15:0] delta, input logic level, input logic read_ok);
    if ($urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - 18){1'b0}}, read_ok, level, delta};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DETENT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_delta();
    int pick;
    int span;
    pick = $urandom_range(99);
    span = 3 * cur_divisor;
    if (pick < 60) begin
      return 16'(int'($urandom_range(2 * span)) - span);
    end else if (pick < 70) begin
      return 16'($urandom);
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    return 16'h0000;
  endfunction

  task automatic send_random_poll();
    logic [15:0] delta;
    delta = pick_delta();
    if ($urandom_range(99) < 40) btn_level = ~btn_level;
    send_poll(delta, btn_level, $urandom_range(99) < 85);
  endtask

  initial begin
    int detent_val;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Writes to unused indexes must leave the reset settings in force.
    write_reg(REG_SPARE_A, 8'h01);
    write_reg(REG_SPARE_B, 8'h00);

    send_poll(16'h0000, 1'b0, 1'b1);
    send_poll(16'h0004, 1'b0, 1'b1);
    send_poll(16'h0000, 1'b0, 1'b1);
    send_poll(16'hFFFC, 1'b0, 1'b1);
    send_poll(16'h0000, 1'b0, 1'b1);
    send_poll(16'h0003, 1'b0, 1'b1);
    send_poll(16'h0001, 1'b0, 1'b1);
    send_poll(16'hFFFD, 1'b0, 1'b1);
    send_poll(16'hFFFF, 1'b0, 1'b1);
    send_poll(16'h0000, 1'b1, 1'b1);
    send_poll(16'h0000, 1'b0, 1'b0);
    send_poll(16'h0000, 1'b0, 1'b1);
    send_poll(16'h7FFF, 1'b1, 1'b1);
    send_poll(16'h8000, 1'b0, 1'b1);
    send_poll(16'h8000, 1'b1, 1'b0);
    repeat (9) send_poll(16'h0000, 1'b0, 1'b0);

    for (int p = 0; p < PLAN_SIZE; p++) begin
      case (p / 4)
        0: begin
          tx_gap_pct   <= 7;
          rx_stall_pct <= 56;
        end
        1: begin
          tx_gap_pct   <= 56;
          rx_stall_pct <= 7;
        end
        default: begin
          tx_gap_pct   <= 0;
          rx_stall_pct <= 0;
        end
      endcase
      settle();
      detent_val = (detent_plan[p] == PLAN_RANDOM) ? $urandom_range(255, 1) : detent_plan[p];
      write_reg(REG_DETENT, 8'(detent_val));
      write_reg(REG_BUTTON, {{(DETENT_W - 1){1'b0}}, enable_plan[p]});
      cur_divisor = (detent_val == 0) ? 1 : detent_val;
      if (p == 9) hold_req <= 1'b1;
      repeat (POLLS_PER_SETTING) send_random_poll();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("encoder_detent_key_events_tb passed");
    end else begin
      $display("encoder_detent_key_events_tb failed");
    end
    $finish;
  end

endmodule
